// ===== rtl/sbc_pkg.sv =====
// sbc_pkg: widths, payload structs, register indexes and fraction helpers
// for the segment box clipper. Used by every module in rtl/.
// No dependencies.
package sbc_pkg;

	localparam int CW = 32;          // coordinate width
	localparam int DW = CW + 1;      // span, entry and exit width
	localparam int PW = 2 * DW;      // parameter times span product
	localparam int QW = CW + 2;      // quotient bits of the scaling divide
	localparam int MW = 2 * DW + 2;  // cross products of the fraction compare
	localparam int LATENCY = QW + 7;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] wnum_t;
	typedef logic [DW-1:0] wden_t;

	typedef enum logic [1:0] {
		HITS_NONE = 2'd0,
		HITS_ONE  = 2'd1,
		HITS_TWO  = 2'd2
	} hits_t;

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_z;
		coord_t end_x;
		coord_t end_y;
		coord_t end_z;
		logic   whole_line;
	} in_t;

	typedef struct packed {
		hits_t  hits;
		coord_t out_start_x;
		coord_t out_start_y;
		coord_t out_start_z;
		coord_t out_end_x;
		coord_t out_end_y;
		coord_t out_end_z;
	} out_t;

	// parameter bound n/d, open means unbounded
	typedef struct packed {
		logic  open;
		wnum_t n;
		wden_t d;
	} frac_t;

	typedef struct packed {
		logic   mov;
		wnum_t  en;
		wnum_t  ex;
		wden_t  den;
		wnum_t  sp;
		coord_t s;
	} axis_t;

	typedef struct packed {
		logic            ok;
		logic            mov_any;
		frac_t           lo;
		frac_t           hi;
		axis_t [2:0]     ax;
	} stage_t;

	typedef struct packed {
		hits_t        hits;
		coord_t [2:0] s;
		logic [2:0]   neg_lo;
		logic [2:0]   neg_hi;
	} side_t;

	function automatic wden_t mag(input wnum_t x);
		begin
			return x[DW-1] ? wden_t'(-x) : wden_t'(x);
		end
	endfunction

	// sign of an/ad - bn/bd for positive ad, bd
	function automatic logic signed [MW-1:0] frac_diff(input wnum_t an, input wden_t ad,
			input wnum_t bn, input wden_t bd);
		logic signed [MW-1:0] ae, be, adx, bdx;
		begin
			ae  = MW'(an);
			be  = MW'(bn);
			adx = MW'({1'b0, ad});
			bdx = MW'({1'b0, bd});
			return ae * bdx - be * adx;
		end
	endfunction

endpackage

// ===== rtl/sbc_prep.sv =====
// sbc_prep: first pipeline stage, spans, slab entry/exit numerators and box checks
// Depends on sbc_pkg.
module sbc_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sbc_pkg::in_t    req,
	input  sbc_pkg::coord_t box_min [3],
	input  sbc_pkg::coord_t box_max [3],
	output logic            vld_s1,
	output sbc_pkg::stage_t st_s1
);

	sbc_pkg::coord_t s_a [3];
	sbc_pkg::coord_t e_a [3];
	sbc_pkg::stage_t st_d;

	assign s_a[0] = req.start_x;
	assign s_a[1] = req.start_y;
	assign s_a[2] = req.start_z;
	assign e_a[0] = req.end_x;
	assign e_a[1] = req.end_y;
	assign e_a[2] = req.end_z;

	always_comb begin
		sbc_pkg::wnum_t sw, ew, mnw, mxw, sp;
		logic ok, mov_any;
		ok = 1'b1;
		mov_any = 1'b0;
		st_d = '0;
		for (int k = 0; k < 3; k++) begin
			sw  = sbc_pkg::DW'(s_a[k]);
			ew  = sbc_pkg::DW'(e_a[k]);
			mnw = sbc_pkg::DW'(box_min[k]);
			mxw = sbc_pkg::DW'(box_max[k]);
			sp  = ew - sw;
			if (box_min[k] > box_max[k])
				ok = 1'b0;
			if (sp == '0 && (s_a[k] < box_min[k] || s_a[k] > box_max[k]))
				ok = 1'b0;
			st_d.ax[k].mov = (sp != '0);
			st_d.ax[k].sp  = sp;
			st_d.ax[k].s   = s_a[k];
			st_d.ax[k].den = sbc_pkg::mag(sp);
			if (!sp[sbc_pkg::DW-1]) begin
				st_d.ax[k].en = mnw - sw;
				st_d.ax[k].ex = mxw - sw;
			end else begin
				st_d.ax[k].en = sw - mxw;
				st_d.ax[k].ex = sw - mnw;
			end
			mov_any = mov_any | (sp != '0);
		end
		st_d.ok      = ok;
		st_d.mov_any = mov_any;
		st_d.lo.open = req.whole_line;
		st_d.lo.n    = '0;
		st_d.lo.d    = sbc_pkg::wden_t'(1);
		st_d.hi.open = req.whole_line;
		st_d.hi.n    = sbc_pkg::wnum_t'(1);
		st_d.hi.d    = sbc_pkg::wden_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		st_s1 <= st_d;
	end

endmodule

// ===== rtl/sbc_slab.sv =====
// sbc_slab: one pipeline stage narrowing the parameter interval by one axis slab
// Depends on sbc_pkg.
module sbc_slab (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_i,
	input  sbc_pkg::stage_t st_i,
	input  sbc_pkg::axis_t  ax_i,
	output logic            vld_o,
	output sbc_pkg::stage_t st_o
);

	sbc_pkg::stage_t st_d;
	logic signed [sbc_pkg::MW-1:0] dlo, dhi;

	assign dlo = sbc_pkg::frac_diff(ax_i.en, ax_i.den, st_i.lo.n, st_i.lo.d);
	assign dhi = sbc_pkg::frac_diff(ax_i.ex, ax_i.den, st_i.hi.n, st_i.hi.d);

	always_comb begin
		st_d = st_i;
		// entry bound keeps the latest, exit bound the earliest
		if (ax_i.mov && (st_i.lo.open || (!dlo[sbc_pkg::MW-1] && dlo != '0))) begin
			st_d.lo.open = 1'b0;
			st_d.lo.n    = ax_i.en;
			st_d.lo.d    = ax_i.den;
		end
		if (ax_i.mov && (st_i.hi.open || dhi[sbc_pkg::MW-1])) begin
			st_d.hi.open = 1'b0;
			st_d.hi.n    = ax_i.ex;
			st_d.hi.d    = ax_i.den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		st_o <= st_d;
	end

endmodule

// ===== rtl/sbc_div.sv =====
// sbc_div: pipelined restoring divider, one quotient bit per stage
// Depends on sbc_pkg.
module sbc_div (
	input  logic                      clk,
	input  logic [sbc_pkg::PW-1:0]    num,
	input  sbc_pkg::wden_t            den,
	output logic [sbc_pkg::QW-1:0]    quo,
	output logic                      rem_nz
);

	localparam int QW = sbc_pkg::QW;
	localparam int DW = sbc_pkg::DW;

	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] sh_s  [QW+1];
	logic [DW-1:0] den_s [QW+1];

	// quotient is known to fit QW bits whenever the result is used
	assign rem_s[0] = DW'(num[sbc_pkg::PW-1:QW]);
	assign sh_s[0]  = num[QW-1:0];
	assign den_s[0] = den;

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_s[g], sh_s[g][QW-1]};
		assign ge    = (trial >= {1'b0, den_s[g]});
		always_ff @(posedge clk) begin
			rem_s[g+1] <= ge ? DW'(trial - {1'b0, den_s[g]}) : trial[DW-1:0];
			sh_s[g+1]  <= {sh_s[g][QW-2:0], ge};
			den_s[g+1] <= den_s[g];
		end
	end

	assign quo    = sh_s[QW];
	assign rem_nz = |rem_s[QW];

endmodule

// ===== rtl/segment_box_clipper_top.sv =====
// segment_box_clipper_top: clips a 3d segment or line against a box by slab intersection
// done rises for a request after it has passed the prep, slab, interval check, product and divider stages.
// Throughput: one request per clock; busy stays low, set by the fully pipelined
// per-axis compare stages and the 34-stage scaling dividers.
// Reset clears the box registers to 0 and empties the pipeline; requests in flight are dropped.
// Depends on sbc_pkg, sbc_prep, sbc_slab, sbc_div.
module segment_box_clipper_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sbc_pkg::in_t        req,
	input  logic                wr_en,
	input  logic [2:0]          wr_idx,
	input  sbc_pkg::coord_t     wr_data,
	output logic                done,
	output sbc_pkg::out_t       result
);

	localparam int QW = sbc_pkg::QW;
	localparam int DW = sbc_pkg::DW;
	localparam int PW = sbc_pkg::PW;
	localparam int MW = sbc_pkg::MW;
	localparam int LATENCY = sbc_pkg::LATENCY;

	sbc_pkg::coord_t box_min_q [3];
	sbc_pkg::coord_t box_max_q [3];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (wr_en) begin
			unique case (sbc_pkg::cfg_idx_t'(wr_idx))
				sbc_pkg::REG_MIN_X: box_min_q[0] <= wr_data;
				sbc_pkg::REG_MIN_Y: box_min_q[1] <= wr_data;
				sbc_pkg::REG_MIN_Z: box_min_q[2] <= wr_data;
				sbc_pkg::REG_MAX_X: box_max_q[0] <= wr_data;
				sbc_pkg::REG_MAX_Y: box_max_q[1] <= wr_data;
				sbc_pkg::REG_MAX_Z: box_max_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1 and the three slab stages
	logic            vld_st [4];
	sbc_pkg::stage_t st_st  [4];

	sbc_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.box_min (box_min_q),
		.box_max (box_max_q),
		.vld_s1  (vld_st[0]),
		.st_s1   (st_st[0])
	);

	for (genvar g = 0; g < 3; g++) begin : g_slab
		sbc_slab u_slab (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_st[g]),
			.st_i   (st_st[g]),
			.ax_i   (st_st[g].ax[g]),
			.vld_o  (vld_st[g+1]),
			.st_o   (st_st[g+1])
		);
	end

	// stage 5: interval check
	sbc_pkg::stage_t st4;
	logic signed [MW-1:0] dint;
	sbc_pkg::hits_t hits_d;

	assign st4  = st_st[3];
	assign dint = sbc_pkg::frac_diff(st4.lo.n, st4.lo.d, st4.hi.n, st4.hi.d);

	always_comb begin
		if (!st4.ok)
			hits_d = sbc_pkg::HITS_NONE;
		else if (!st4.mov_any)
			hits_d = sbc_pkg::HITS_ONE;
		else if (!dint[MW-1] && dint != '0)
			hits_d = sbc_pkg::HITS_NONE;
		else if (dint == '0)
			hits_d = sbc_pkg::HITS_ONE;
		else
			hits_d = sbc_pkg::HITS_TWO;
	end

	logic            vld_s5;
	sbc_pkg::hits_t  hits_s5;
	sbc_pkg::frac_t  lo_s5, hi_s5;
	sbc_pkg::wnum_t  sp_s5 [3];
	sbc_pkg::coord_t s_s5  [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_st[3];
	end

	always_ff @(posedge clk) begin
		hits_s5 <= hits_d;
		lo_s5   <= st4.lo;
		hi_s5   <= st4.hi;
		for (int k = 0; k < 3; k++) begin
			sp_s5[k] <= st4.ax[k].sp;
			s_s5[k]  <= st4.ax[k].s;
		end
	end

	// stage 6: parameter times span magnitudes
	logic            vld_s6;
	logic [PW-1:0]   plo_s6 [3];
	logic [PW-1:0]   phi_s6 [3];
	sbc_pkg::wden_t  dlo_s6, dhi_s6;
	sbc_pkg::side_t  side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		dlo_s6       <= lo_s5.d;
		dhi_s6       <= hi_s5.d;
		side_s6.hits <= hits_s5;
		for (int k = 0; k < 3; k++) begin
			plo_s6[k]          <= PW'(sbc_pkg::mag(lo_s5.n)) * PW'(sbc_pkg::mag(sp_s5[k]));
			phi_s6[k]          <= PW'(sbc_pkg::mag(hi_s5.n)) * PW'(sbc_pkg::mag(sp_s5[k]));
			side_s6.s[k]       <= s_s5[k];
			side_s6.neg_lo[k]  <= lo_s5.n[DW-1] ^ sp_s5[k][DW-1];
			side_s6.neg_hi[k]  <= hi_s5.n[DW-1] ^ sp_s5[k][DW-1];
		end
	end

	// scaling dividers, sideband travels alongside
	logic [QW-1:0] qlo [3];
	logic [QW-1:0] qhi [3];
	logic [2:0]    rlo, rhi;

	for (genvar g = 0; g < 3; g++) begin : g_div
		sbc_div u_div_lo (
			.clk    (clk),
			.num    (plo_s6[g]),
			.den    (dlo_s6),
			.quo    (qlo[g]),
			.rem_nz (rlo[g])
		);
		sbc_div u_div_hi (
			.clk    (clk),
			.num    (phi_s6[g]),
			.den    (dhi_s6),
			.quo    (qhi[g]),
			.rem_nz (rhi[g])
		);
	end

	logic           vld_dly_q  [QW];
	sbc_pkg::side_t side_dly_q [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++)
				vld_dly_q[k] <= 1'b0;
		end else begin
			vld_dly_q[0] <= vld_s6;
			for (int k = 1; k < QW; k++)
				vld_dly_q[k] <= vld_dly_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_dly_q[0] <= side_s6;
		for (int k = 1; k < QW; k++)
			side_dly_q[k] <= side_dly_q[k-1];
	end

	// floor with sign, then offset from the start point
	sbc_pkg::side_t  sd;
	sbc_pkg::coord_t pst [3];
	sbc_pkg::coord_t pen [3];

	assign sd = side_dly_q[QW-1];

	always_comb begin
		logic signed [QW:0] fl, fh, sx, ql, qh;
		for (int k = 0; k < 3; k++) begin
			ql = $signed({1'b0, qlo[k]});
			qh = $signed({1'b0, qhi[k]});
			sx = (QW+1)'(sd.s[k]);
			fl = sd.neg_lo[k] ? (-ql - (QW+1)'(rlo[k])) : ql;
			fh = sd.neg_hi[k] ? (-qh - (QW+1)'(rhi[k])) : qh;
			pst[k] = sbc_pkg::coord_t'(sx + fl);
			pen[k] = sbc_pkg::coord_t'(sx + fh);
			if (sd.hits == sbc_pkg::HITS_NONE) begin
				pst[k] = '0;
				pen[k] = '0;
			end else if (sd.hits == sbc_pkg::HITS_ONE) begin
				pen[k] = pst[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_dly_q[QW-1];
	end

	always_ff @(posedge clk) begin
		result.hits        <= sd.hits;
		result.out_start_x <= pst[0];
		result.out_start_y <= pst[1];
		result.out_start_z <= pst[2];
		result.out_end_x   <= pen[0];
		result.out_end_y   <= pen[1];
		result.out_end_z   <= pen[2];
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not produce a result on time");

	a_no_code3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hits == sbc_pkg::HITS_NONE || result.hits == sbc_pkg::HITS_ONE ||
			result.hits == sbc_pkg::HITS_TWO))
		else $error("hit count out of range");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hits == sbc_pkg::HITS_NONE) |->
		(result.out_start_x == '0 && result.out_start_y == '0 && result.out_start_z == '0 &&
		 result.out_end_x == '0 && result.out_end_y == '0 && result.out_end_z == '0))
		else $error("rejected request carries coordinates");

	a_touch_same: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hits == sbc_pkg::HITS_ONE) |->
		(result.out_end_x == result.out_start_x && result.out_end_y == result.out_start_y &&
		 result.out_end_z == result.out_start_z))
		else $error("touching point has two different ends");

endmodule
